// ===== rtl/sle_pkg.sv =====
// sle_pkg: shared types and constants for the sorted list engine
// operation and status codes, controller command and status structs
// no dependencies
package sle_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_REVERSE = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;
        logic upd_run;
        logic fin;
        logic rd_run;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic upd_end;
        logic rd_end;
    } t_stat;

endpackage

// ===== rtl/sle_ctrl.sv =====
// sle_ctrl: operation sequencer for the sorted list engine
// steps idle, copy pass, commit and readout; depends on sle_pkg
module sle_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output sle_pkg::t_cmd  o_cmd,
    input  sle_pkg::t_stat i_stat
);
    import sle_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_UPD  = 4'b0010,
        S_FIN  = 4'b0100,
        S_RD   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_UPD;
            end
            S_UPD: begin
                if (i_stat.upd_end) n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_RD;
            end
            S_RD: begin
                if (i_stat.rd_end) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.start   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.upd_run = (r_state == S_UPD);
    assign o_cmd.fin     = (r_state == S_FIN);
    assign o_cmd.rd_run  = (r_state == S_RD);

endmodule

// ===== rtl/sle_datapath.sv =====
// sle_datapath: two-bank list memory, copy pass that inserts, deletes or
// reverses, count and order registers, and the result register; uses sle_pkg
module sle_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sle_pkg::t_cmd                   i_cmd,
    output sle_pkg::t_stat                  o_stat,
    input  sle_pkg::t_op                    i_op,
    input  logic signed [sle_pkg::WORD_W-1:0] i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [sle_pkg::WORD_W-1:0] o_out_value,
    output logic                            o_out_has,
    output logic                            o_out_last,
    output sle_pkg::t_status                o_out_status,
    output logic [sle_pkg::COUNT_W-1:0]     o_out_count
);
    import sle_pkg::*;

    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int AW    = IW + 1;
    localparam int MEM_N = 2 ** AW;

    // list memory: bank bit on top, element index below
    logic signed [WORD_W-1:0] r_mem [MEM_N];
    logic signed [WORD_W-1:0] r_rd_data;
    logic [AW-1:0]            raddr;
    logic [AW-1:0]            waddr;
    logic                     we;
    logic signed [WORD_W-1:0] wdata;

    t_op                      r_op;
    logic signed [WORD_W-1:0] r_val;
    t_status                  r_status;
    logic                     r_copy;
    logic [CW-1:0]            r_len;
    logic [CW-1:0]            r_ri;
    logic                     r_dv;
    logic [CW-1:0]            r_wj;
    logic                     r_ins;
    logic signed [WORD_W-1:0] r_hold;
    logic [CW-1:0]            r_cnt;
    logic                     r_asc;
    logic                     r_bank;
    logic [CW-1:0]            r_p;
    logic                     r_pre;
    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_out_value;
    logic                     r_out_has;
    logic                     r_out_last;
    t_status                  r_out_status;
    logic [COUNT_W-1:0]       r_out_count;

    t_status       n_status;
    logic          n_copy;
    logic          cnt_empty;
    logic          cnt_full;
    logic          ins_take;
    logic          load;
    logic          adv;
    logic          rd_last;
    logic [CW-1:0] rd_idx;

    function automatic logic goes_before(input logic signed [WORD_W-1:0] a,
                                         input logic signed [WORD_W-1:0] b,
                                         input logic asc);
        return asc ? (a < b) : (a > b);
    endfunction

    assign cnt_empty = (r_cnt == '0);
    assign cnt_full  = (r_cnt == CW'(DEPTH));

    // status and copy decision taken when the transaction is accepted
    always_comb begin
        n_status = ST_OK;
        n_copy   = 1'b0;
        case (i_op)
            OP_INSERT: begin
                n_status = cnt_full ? ST_FULL : ST_OK;
                n_copy   = !cnt_full;
            end
            OP_DELETE, OP_REVERSE: begin
                n_status = cnt_empty ? ST_EMPTY : ST_OK;
                n_copy   = 1'b1;
            end
            OP_CLEAR: begin
                n_status = cnt_empty ? ST_EMPTY : ST_OK;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // copy pass write side; after the insert point the stream runs one behind
    always_comb begin
        we       = 1'b0;
        wdata    = r_rd_data;
        ins_take = 1'b0;
        if (i_cmd.upd_run && r_dv) begin
            case (r_op)
                OP_INSERT: begin
                    we = 1'b1;
                    if (!r_ins && goes_before(r_val, r_rd_data, r_asc)) begin
                        wdata    = r_val;
                        ins_take = 1'b1;
                    end else if (r_ins) begin
                        wdata = r_hold;
                    end
                end
                OP_DELETE: begin
                    we = (r_rd_data != r_val);
                end
                OP_REVERSE: begin
                    we = 1'b1;
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end else if (i_cmd.fin && r_copy && (r_op == OP_INSERT)) begin
            we    = 1'b1;
            wdata = r_ins ? r_hold : r_val;
        end
    end

    assign load    = i_cmd.rd_run && (!r_out_valid || i_out_ready);
    assign adv     = load && r_pre && !cnt_empty;
    assign rd_last = (r_p == r_cnt - CW'(1));

    always_comb begin
        if (i_cmd.rd_run) begin
            rd_idx = adv ? r_p + CW'(1) : r_p;
        end else if (r_op == OP_REVERSE) begin
            rd_idx = r_len - r_ri - CW'(1);
        end else begin
            rd_idx = r_ri;
        end
    end

    assign raddr = {r_bank, rd_idx[IW-1:0]};
    assign waddr = {~r_bank, r_wj[IW-1:0]};

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_data <= r_mem[raddr];
    end

    assign o_stat.upd_end = (r_ri == r_len) && !r_dv;
    assign o_stat.rd_end  = load && (cnt_empty || (r_pre && rd_last));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_asc       <= 1'b1;
            r_bank      <= 1'b0;
            r_ri        <= '0;
            r_dv        <= 1'b0;
            r_wj        <= '0;
            r_ins       <= 1'b0;
            r_p         <= '0;
            r_pre       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_ri  <= '0;
                r_dv  <= 1'b0;
                r_wj  <= '0;
                r_ins <= 1'b0;
            end
            if (i_cmd.upd_run) begin
                r_dv <= (r_ri != r_len);
                if (r_ri != r_len) r_ri <= r_ri + CW'(1);
                if (we) r_wj <= r_wj + CW'(1);
                if (ins_take) r_ins <= 1'b1;
            end
            if (i_cmd.fin) begin
                r_p <= '0;
                if (r_copy) begin
                    r_bank <= ~r_bank;
                    r_cnt  <= (r_op == OP_INSERT) ? r_wj + CW'(1) : r_wj;
                end
                if (r_op == OP_CLEAR) r_cnt <= '0;
                if (r_op == OP_REVERSE) r_asc <= ~r_asc;
            end
            r_pre <= i_cmd.rd_run && !o_stat.rd_end;
            if (adv) r_p <= r_p + CW'(1);
            if (load && (cnt_empty || r_pre)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op     <= i_op;
            r_val    <= i_value;
            r_status <= n_status;
            r_copy   <= n_copy;
            r_len    <= n_copy ? r_cnt : '0;
        end
        if (i_cmd.upd_run && r_dv && (r_op == OP_INSERT) && (ins_take || r_ins)) begin
            r_hold <= r_rd_data;
        end
        if (load && cnt_empty) begin
            r_out_value  <= '0;
            r_out_has    <= 1'b0;
            r_out_last   <= 1'b1;
            r_out_status <= r_status;
            r_out_count  <= COUNT_W'(r_cnt);
        end else if (adv) begin
            r_out_value  <= r_rd_data;
            r_out_has    <= 1'b1;
            r_out_last   <= rd_last;
            r_out_status <= r_status;
            r_out_count  <= COUNT_W'(r_cnt);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_has    = r_out_has;
    assign o_out_last   = r_out_last;
    assign o_out_status = r_out_status;
    assign o_out_count  = r_out_count;

endmodule

// ===== rtl/sorted_list_engine.sv =====
// sorted_list_engine: top level of the bounded sorted list
// joins sle_ctrl and sle_datapath; uses sle_pkg
//
//  channel   dir  ready    payload
//  s_axis    in   tready   tdata: value[31:0]; tuser: op[1:0]
//  m_axis    out  tready   tdata: item_value, list_count; tuser: has_value, status; tlast
//
//  an accept step, a copy pass over the n stored elements (over none when nothing
//  is copied) that reads one memory bank while writing the other, a commit step,
//  a prefetch unless the list is empty, then the readout of the results; reset is
//  synchronous and the memory needs no clearing pass; a low m_axis_tready holds the
//  readout, and the next transaction is taken after the last result loads
module sorted_list_engine #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // item_value[31:0], list_count[36:32], zero
    output logic [2:0]  m_axis_tuser,   // has_value[0], status[2:1]
    output logic        m_axis_tlast
);
    import sle_pkg::*;

    t_cmd                     cmd;
    t_stat                    stat;
    logic signed [WORD_W-1:0] out_value;
    logic                     out_has;
    t_status                  out_status;
    logic [COUNT_W-1:0]       out_count;

    sle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    sle_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_op         (t_op'(s_axis_tuser)),
        .i_value      (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_value  (out_value),
        .o_out_has    (out_has),
        .o_out_last   (m_axis_tlast),
        .o_out_status (out_status),
        .o_out_count  (out_count)
    );

    assign m_axis_tdata = {3'b000, out_count, out_value};
    assign m_axis_tuser = {out_status, out_has};

    // one transaction at a time on the input side
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an operation is in progress");

    // a result that holds no element is always the whole run
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("empty result not marked last");

    // a dropped insert means the list is full, so the readout has elements
    a_full_has_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:1] == ST_FULL)) |-> m_axis_tuser[0])
        else $error("full status on an empty result");

endmodule

// ===== test/sorted_list_engine_test.sv =====
// sorted_list_engine_test: self-checking bench for the bounded sorted list engine
// predicts every readout transaction with a scoreboard class; drives both stream sides
// depends on sle_pkg and sorted_list_engine
module sorted_list_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sle_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AT_ITEM = 150;

    typedef struct {
        logic signed [WORD_W-1:0]   item_value;
        logic                       has_value;
        logic                       last;
        logic        [STATUS_W-1:0] status;
        logic        [COUNT_W-1:0]  list_count;
    } t_readout;

    class list_scoreboard;
        logic signed [WORD_W-1:0] vals [LIST_DEPTH];
        int                       count;
        bit                       ascending;
        t_readout                 pending_q [$];
        int                       errors;

        function new();
            count     = 0;
            ascending = 1'b1;
            errors    = 0;
        endfunction

        function void push_readout(logic signed [WORD_W-1:0] v, logic has, logic last,
                                   t_status status);
            t_readout r;
            r.item_value = v;
            r.has_value  = has;
            r.last       = last;
            r.status     = status;
            r.list_count = count[COUNT_W-1:0];
            pending_q.push_back(r);
        endfunction

        // update the list for one accepted operation and queue its readout
        function void note_op(t_op op, logic signed [WORD_W-1:0] v);
            t_status                  status;
            int                       pos;
            int                       j;
            bit                       found;
            logic signed [WORD_W-1:0] tmp;
            status = ST_OK;
            case (op)
                OP_INSERT: begin
                    if (count >= LIST_DEPTH) begin
                        status = ST_FULL;
                    end else begin
                        pos   = count;
                        found = 1'b0;
                        // equal values go after the copies already stored
                        for (int i = 0; i < count; i++) begin
                            if (!found && (ascending ? (v < vals[i]) : (v > vals[i]))) begin
                                pos   = i;
                                found = 1'b1;
                            end
                        end
                        for (int i = count; i > pos; i--) vals[i] = vals[i-1];
                        vals[pos] = v;
                        count++;
                    end
                end
                OP_DELETE: begin
                    if (count == 0) begin
                        status = ST_EMPTY;
                    end else begin
                        j = 0;
                        for (int i = 0; i < count; i++) begin
                            if (vals[i] !== v) begin
                                vals[j] = vals[i];
                                j++;
                            end
                        end
                        count = j;
                    end
                end
                OP_REVERSE: begin
                    if (count == 0) status = ST_EMPTY;
                    for (int i = 0; i < count / 2; i++) begin
                        tmp               = vals[i];
                        vals[i]           = vals[count-1-i];
                        vals[count-1-i]   = tmp;
                    end
                    ascending = !ascending;
                end
                default: begin
                    status = (count == 0) ? ST_EMPTY : ST_OK;
                    count  = 0;
                    push_readout('0, 1'b0, 1'b1, status);
                    return;
                end
            endcase
            if (count == 0) begin
                push_readout('0, 1'b0, 1'b1, status);
            end else begin
                for (int i = 0; i < count; i++)
                    push_readout(vals[i], 1'b1, (i == count - 1), status);
            end
        endfunction

        function void report(string field, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: mismatch on %s: expected %0h, actual %0h",
                         $time, field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_readout got);
            t_readout exp_r;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result: item_value %0h has %0b last %0b status %0d",
                         $time, got.item_value, got.has_value, got.last, got.status);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            report("item_value", exp_r.item_value, got.item_value);
            report("has_value", WORD_W'(exp_r.has_value), WORD_W'(got.has_value));
            report("last", WORD_W'(exp_r.last), WORD_W'(got.last));
            report("status", WORD_W'(exp_r.status), WORD_W'(got.status));
            report("list_count", WORD_W'(exp_r.list_count), WORD_W'(got.list_count));
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // value[31:0]
    logic [1:0]  s_axis_tuser  = '0;   // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // item_value[31:0], list_count[36:32], zero
    logic [2:0]  m_axis_tuser;         // has_value[0], status[2:1]
    logic        m_axis_tlast;

    list_scoreboard sb = new();

    int burst_left = 0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;
    int hold_left  = 0;
    int stall_mode = 0;
    int mode_left  = 0;
    int tick       = 0;

    sorted_list_engine #(.DEPTH(LIST_DEPTH)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: switches between stall patterns, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            tick <= tick + 1;
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= (tick % 4 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_readout got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.item_value = m_axis_tdata[31:0];
            got.list_count = m_axis_tdata[36:32];
            got.has_value  = m_axis_tuser[0];
            got.status     = m_axis_tuser[2:1];
            got.last       = m_axis_tlast;
            sb.check_result(got);
        end
    end

    task automatic send_op(input t_op op, input logic [31:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_op(op, value);
    endtask

    // mix of small values (duplicates), extremes, stored values (delete hits) and noise
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3 && sb.count > 0) return sb.vals[$urandom_range(0, sb.count - 1)];
        if (sel < 6) return $urandom_range(0, 8) - 4;
        if (sel == 6) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    initial begin
        int   n_random;
        int   phase_kind;
        int   phase_len;
        int   roll;
        t_op  op;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty-list cases
        send_op(OP_REVERSE, 32'h0);
        send_op(OP_DELETE, 32'h5);
        send_op(OP_CLEAR, 32'h0);
        // extremes and equal values
        send_op(OP_INSERT, 32'h8000_0000);
        send_op(OP_INSERT, 32'h7FFF_FFFF);
        send_op(OP_INSERT, 32'h0);
        send_op(OP_INSERT, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 32'd7);
        send_op(OP_INSERT, 32'd7);
        for (int i = 0; i < 10; i++) send_op(OP_INSERT, 1000 + $urandom_range(0, 50));
        // full list drops the insert
        send_op(OP_INSERT, 32'd9);
        send_op(OP_DELETE, 32'd3);
        send_op(OP_REVERSE, 32'h0);
        send_op(OP_DELETE, 32'd7);
        send_op(OP_INSERT, 32'hFFFF_FFFF);
        send_op(OP_CLEAR, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 32'd42);
        send_op(OP_DELETE, 32'd42);
        send_op(OP_REVERSE, 32'hFFFF_FFFF);

        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            phase_kind = $urandom_range(0, 3);
            phase_len  = $urandom_range(8, 40);
            for (int k = 0; k < phase_len && n_random < RANDOM_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                case (phase_kind)
                    0: op = (roll < 85) ? OP_INSERT : (roll < 92) ? OP_DELETE :
                            (roll < 97) ? OP_REVERSE : OP_CLEAR;
                    1: op = (roll < 30) ? OP_INSERT : (roll < 85) ? OP_DELETE :
                            (roll < 95) ? OP_REVERSE : OP_CLEAR;
                    default: op = (roll < 45) ? OP_INSERT : (roll < 75) ? OP_DELETE :
                                  (roll < 92) ? OP_REVERSE : OP_CLEAR;
                endcase
                // receiver backs off while the sender keeps offering
                if (n_random == HOLD_AT_ITEM) hold_req <= 1'b1;
                send_op(op, pick_value());
                n_random++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.pending_q.size() != 0) sb.errors++;
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
